FILE: rtl/core/rsf_pkg.sv
// Shared codes and types for the range spike filter.
package rsf_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int INTENSITY_BITS = 16;

   typedef enum logic [1:0] {
      KIND_FIN = 2'd0,
      KIND_INF = 2'd1,
      KIND_NAN = 2'd2,
      KIND_BAD = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_MIN_RANGE = 2'd1,
      REG_MAX_RANGE = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

FILE: rtl/core/rsf_csr.sv
// Configuration registers of the range spike filter behind an APB-style port.
module rsf_csr
   import rsf_pkg::*;
#(
   parameter int RANGE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [RANGE_BITS-1:0]    threshold,
   output logic [RANGE_BITS-1:0]    min_range,
   output logic [RANGE_BITS-1:0]    max_range
);

   logic [RANGE_BITS-1:0] threshold_ff;
   logic [RANGE_BITS-1:0] min_range_ff;
   logic [RANGE_BITS-1:0] max_range_ff;
   reg_index_type         index;
   logic                  write_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RANGE_BITS'(200);
         min_range_ff <= '0;
         max_range_ff <= '1;
      end else if (write_en) begin
         case (index)
            REG_THRESHOLD: threshold_ff <= csr_pwdata[RANGE_BITS-1:0];
            REG_MIN_RANGE: min_range_ff <= csr_pwdata[RANGE_BITS-1:0];
            REG_MAX_RANGE: max_range_ff <= csr_pwdata[RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_THRESHOLD: csr_prdata = CSR_DATA_BITS'(threshold_ff);
         REG_MIN_RANGE: csr_prdata = CSR_DATA_BITS'(min_range_ff);
         REG_MAX_RANGE: csr_prdata = CSR_DATA_BITS'(max_range_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign threshold = threshold_ff;
   assign min_range = min_range_ff;
   assign max_range = max_range_ff;

endmodule

FILE: rtl/core/rsf_window.sv
// Sample window and outlier decision of the range spike filter.
module rsf_window
   import rsf_pkg::*;
#(
   parameter int RANGE_BITS = 16,
   parameter int ENTRY_BITS = RANGE_BITS + INTENSITY_BITS + 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [RANGE_BITS-1:0]     range_mm,
   input  logic [1:0]                range_kind,
   input  logic [INTENSITY_BITS-1:0] intensity,
   input  logic                      intensity_present,
   input  logic                      scan_last,
   input  logic [RANGE_BITS-1:0]     threshold,
   input  logic [RANGE_BITS-1:0]     min_range,
   input  logic [RANGE_BITS-1:0]     max_range,
   output push_type                  push,
   output logic [ENTRY_BITS-1:0]     slot0,
   output logic [ENTRY_BITS-1:0]     slot1
);

   typedef struct packed {
      logic [RANGE_BITS-1:0]     range_mm;
      logic [1:0]                kind;
      logic [INTENSITY_BITS-1:0] intensity;
      logic                      present;
      logic                      last;
   } entry_type;

   logic [RANGE_BITS-1:0]     prior_range_ff, prior_range_in;
   kind_type                  prior_kind_ff, prior_kind_in;
   logic                      prior_exists_ff, prior_exists_in;
   logic [RANGE_BITS-1:0]     held_range_ff, held_range_in;
   kind_type                  held_kind_ff, held_kind_in;
   logic [INTENSITY_BITS-1:0] held_intensity_ff, held_intensity_in;
   logic                      held_present_ff, held_present_in;
   logic                      held_exists_ff, held_exists_in;

   kind_type                  new_kind;
   logic [RANGE_BITS-1:0]     diff_prior;
   logic [RANGE_BITS-1:0]     diff_next;
   logic                      far_prior;
   logic                      far_next;
   logic                      outlier;
   logic [RANGE_BITS-1:0]     fil_range;
   kind_type                  fil_kind;
   logic [INTENSITY_BITS-1:0] fil_intensity;
   entry_type                 held_entry;
   entry_type                 last_entry;

   assign new_kind = (range_kind == KIND_BAD) ? KIND_NAN : kind_type'(range_kind);

   assign diff_prior = (held_range_ff >= prior_range_ff) ? held_range_ff - prior_range_ff
                                                         : prior_range_ff - held_range_ff;
   assign diff_next  = (held_range_ff >= range_mm) ? held_range_ff - range_mm
                                                   : range_mm - held_range_ff;

   always_comb begin
      case (prior_kind_ff)
         KIND_INF: far_prior = 1'b1;
         KIND_FIN: far_prior = diff_prior > threshold;
         default:  far_prior = 1'b0;
      endcase
      case (new_kind)
         KIND_INF: far_next = 1'b1;
         KIND_FIN: far_next = diff_next > threshold;
         default:  far_next = 1'b0;
      endcase
   end

   assign outlier = prior_exists_ff && (held_kind_ff == KIND_FIN) &&
                    (held_range_ff >= min_range) && (held_range_ff <= max_range) &&
                    far_prior && far_next;

   assign fil_range     = outlier ? '0 : held_range_ff;
   assign fil_kind      = outlier ? KIND_INF : held_kind_ff;
   assign fil_intensity = outlier ? '0 : held_intensity_ff;

   always_comb begin
      held_entry.range_mm  = (fil_kind == KIND_FIN) ? fil_range : '0;
      held_entry.kind      = fil_kind;
      held_entry.intensity = held_present_ff ? fil_intensity : '0;
      held_entry.present   = held_present_ff;
      held_entry.last      = 1'b0;
      last_entry.range_mm  = (new_kind == KIND_FIN) ? range_mm : '0;
      last_entry.kind      = new_kind;
      last_entry.intensity = intensity_present ? intensity : '0;
      last_entry.present   = intensity_present;
      last_entry.last      = 1'b1;
   end

   assign slot0       = held_exists_ff ? held_entry : last_entry;
   assign slot1       = last_entry;
   assign push.first  = accept & (held_exists_ff | scan_last);
   assign push.second = accept & held_exists_ff & scan_last;

   always_comb begin
      prior_range_in    = prior_range_ff;
      prior_kind_in     = prior_kind_ff;
      prior_exists_in   = prior_exists_ff;
      held_range_in     = held_range_ff;
      held_kind_in      = held_kind_ff;
      held_intensity_in = held_intensity_ff;
      held_present_in   = held_present_ff;
      held_exists_in    = held_exists_ff;
      if (accept) begin
         if (held_exists_ff) begin
            prior_range_in  = fil_range;
            prior_kind_in   = fil_kind;
            prior_exists_in = 1'b1;
         end
         if (scan_last) begin
            prior_exists_in = 1'b0;
            held_exists_in  = 1'b0;
         end else begin
            held_range_in     = range_mm;
            held_kind_in      = new_kind;
            held_intensity_in = intensity;
            held_present_in   = intensity_present;
            held_exists_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_exists_ff <= 1'b0;
         held_exists_ff  <= 1'b0;
      end else begin
         prior_exists_ff <= prior_exists_in;
         held_exists_ff  <= held_exists_in;
      end
      prior_range_ff    <= prior_range_in;
      prior_kind_ff     <= prior_kind_in;
      held_range_ff     <= held_range_in;
      held_kind_ff      <= held_kind_in;
      held_intensity_ff <= held_intensity_in;
      held_present_ff   <= held_present_in;
   end

`ifndef SYNTHESIS
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      accept && scan_last |=> !held_exists_ff && !prior_exists_ff)
      else $error("window not emptied after last request");
   a_hold_next: assert property (@(posedge clock) disable iff (reset)
      accept && !scan_last |=> held_exists_ff)
      else $error("request not held after accept");
   a_prior_needs_held: assert property (@(posedge clock) disable iff (reset)
      prior_exists_ff |-> held_exists_ff)
      else $error("filtered predecessor without held request");
`endif

endmodule

FILE: rtl/core/rsf_out_queue.sv
// Result queue of the range spike filter: takes up to two results a cycle, gives one.
module rsf_out_queue
   import rsf_pkg::*;
#(
   parameter int ENTRY_BITS = 36
) (
   input  logic                  clock,
   input  logic                  reset,
   input  push_type              push,
   input  logic [ENTRY_BITS-1:0] slot0,
   input  logic [ENTRY_BITS-1:0] slot1,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ENTRY_BITS-1:0] out_entry
);

   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [ENTRY_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  pop;
   logic [CNT_BITS-1:0]   pushed;

   assign pop       = out_valid & out_ready;
   assign pushed    = CNT_BITS'(push.first) + CNT_BITS'(push.second);
   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign space     = count_ff <= CNT_BITS'(DEPTH - 2);

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(pushed);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + pushed - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= slot0;
      end
      if (push.second) begin
         mem_ff[wr_ptr_ff + PTR_BITS'(1)] <= slot1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("result queue overflow");
   a_second_with_first: assert property (@(posedge clock) disable iff (reset)
      push.second |-> push.first)
      else $error("second result pushed alone");
   a_push_needs_space: assert property (@(posedge clock) disable iff (reset)
      push.first |-> count_ff <= CNT_BITS'(DEPTH - 2))
      else $error("result pushed without room");
`endif

endmodule

FILE: rtl/core/range_spike_filter_unit.sv
// Top level of the range spike filter: isolated point outlier removal on a scan stream.
//
// Requests enter on the req_ channel (valid/ready), one scan sample each; results leave
// on the rsp_ channel (valid/ready) in scan order. Thresholds are set through the csr_
// APB-style port: threshold at 0x0, minimum range at 0x4, maximum range at 0x8.
// A sample is held back until its successor arrives, so its result is written into the
// result queue when the next request is accepted. A request marked scan_last releases
// the held sample and itself, so it yields two results, both written into the queue
// when it is accepted. A scan of one sample is written into the queue when accepted.
// Throughput is one request per cycle while req_ready is high; the four-entry result
// queue absorbs the double result of a last sample while the receiver keeps taking one
// result a cycle. req_ready drops when the queue cannot take two more results, so a
// stalled receiver stalls the sender after at most four requests; nothing is dropped.
// Reset empties the window and the queue and loads the register reset values.
module range_spike_filter_unit
   import rsf_pkg::*;
#(
   parameter int RANGE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [RANGE_BITS-1:0]     req_range_mm,
   input  logic [1:0]                req_range_kind,
   input  logic [INTENSITY_BITS-1:0] req_intensity,
   input  logic                      req_intensity_present,
   input  logic                      req_scan_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RANGE_BITS-1:0]     rsp_out_range_mm,
   output logic [1:0]                rsp_out_range_kind,
   output logic [INTENSITY_BITS-1:0] rsp_out_intensity,
   output logic                      rsp_out_intensity_present,
   output logic                      rsp_out_last,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   localparam int ENTRY_BITS = RANGE_BITS + INTENSITY_BITS + 4;

   logic [RANGE_BITS-1:0] threshold;
   logic [RANGE_BITS-1:0] min_range;
   logic [RANGE_BITS-1:0] max_range;
   logic                  accept;
   push_type              push;
   logic [ENTRY_BITS-1:0] slot0;
   logic [ENTRY_BITS-1:0] slot1;
   logic [ENTRY_BITS-1:0] out_entry;

   assign accept = req_valid & req_ready;

   rsf_csr #(
      .RANGE_BITS(RANGE_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold),
      .min_range   (min_range),
      .max_range   (max_range)
   );

   rsf_window #(
      .RANGE_BITS(RANGE_BITS),
      .ENTRY_BITS(ENTRY_BITS)
   ) u_window (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .range_mm          (req_range_mm),
      .range_kind        (req_range_kind),
      .intensity         (req_intensity),
      .intensity_present (req_intensity_present),
      .scan_last         (req_scan_last),
      .threshold         (threshold),
      .min_range         (min_range),
      .max_range         (max_range),
      .push              (push),
      .slot0             (slot0),
      .slot1             (slot1)
   );

   rsf_out_queue #(
      .ENTRY_BITS(ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .slot0     (slot0),
      .slot1     (slot1),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_entry (out_entry)
   );

   assign rsp_out_range_mm          = out_entry[ENTRY_BITS-1 -: RANGE_BITS];
   assign rsp_out_range_kind        = out_entry[INTENSITY_BITS+3 -: 2];
   assign rsp_out_intensity         = out_entry[INTENSITY_BITS+1 -: INTENSITY_BITS];
   assign rsp_out_intensity_present = out_entry[1];
   assign rsp_out_last              = out_entry[0];

endmodule
